### hdl/block_probability_normalizer_defines.svh
// Assertion macros for the block probability normalizer.
`ifndef BLOCK_PROBABILITY_NORMALIZER_DEFINES_SVH
`define BLOCK_PROBABILITY_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define BPN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpn assertion failed");

// Next-cycle implication, checked out of reset
`define BPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpn assertion failed");

`else

`define BPN_ASSERT_SAME(label, clk, rst, ante, cons)
`define BPN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/bpn_pkg.sv
// Shared types and constants for the block probability normalizer.
package bpn_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int IDX_W     = $clog2(MAX_BLOCK);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 36;
  localparam int QUOT_W    = 32;
  localparam int FRAC_W    = 31;
  localparam int CFG_W     = 5;
  localparam int BITS_W    = 5;

  localparam logic [CFG_W-1:0]  BLOCK_SIZE_RESET = CFG_W'(4);
  localparam logic [CNT_W-1:0]  MAX_BLOCK_CNT    = CNT_W'(MAX_BLOCK);
  // last index of the serial quotient loop (FRAC_W steps)
  localparam logic [BITS_W-1:0] LAST_BIT         = BITS_W'(FRAC_W - 1);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

### hdl/block_probability_normalizer.sv
// Block probability normalizer: buffers a block, then divides each value by the block sum.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_wr_data                        | in
//  in      | in_valid, in_stall, prob_value                | in
//  out     | out_valid, out_stall, cond_value, block_last, | out
//          | zero_sum                                      |
//
// While a block fills, in_stall is low and every valid value is taken.
// Once a block closes, each buffered value goes through buffer read, setup,
// 31 steps of the one-bit-per-cycle restoring divider, and one output load.
// A zero-sum block skips the divider. No input is taken while a block drains.
// An output stall holds the divider in its output-load state.
// Reset (rst, synchronous) restores block_size to 4 and empties the open block.
`include "block_probability_normalizer_defines.svh"

module block_probability_normalizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bpn_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bpn_pkg::DATA_W-1:0]   prob_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpn_pkg::QUOT_W-1:0]   cond_value,
  output logic                         block_last,
  output logic                         zero_sum
);
  import bpn_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]  block_size;
  logic [CNT_W-1:0]  eff_size;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  blk_len;
  logic [SUM_W-1:0]  block_sum;
  logic [DATA_W-1:0] block_buffer [MAX_BLOCK];
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_data;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    rem_sh;
  logic [SUM_W:0]    rem_diff;
  logic [SUM_W:0]    val_diff;
  logic [QUOT_W-1:0] quot;
  logic [BITS_W-1:0] bit_cnt;
  logic              sum_zero;
  logic              in_accept;
  logic              closes;
  logic              out_free;
  logic              idx_last;

  // effective block size: zero means one, larger than the buffer saturates
  always_comb begin
    priority if (block_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(block_size) > MAX_BLOCK_CNT) begin
      eff_size = MAX_BLOCK_CNT;
    end else begin
      eff_size = CNT_W'(block_size);
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign fill_inc  = fill_count + CNT_W'(1);
  assign closes    = fill_inc >= eff_size;
  assign sum_zero  = (block_sum == '0);
  assign out_free  = !out_valid || !out_stall;
  assign idx_last  = (CNT_W'(rd_idx) + CNT_W'(1)) == blk_len;

  // divider step: shift remainder, trial subtract
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, block_sum};
  assign val_diff = {{(SUM_W + 1 - DATA_W){1'b0}}, rd_data} - {1'b0, block_sum};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
    end else if (cfg_wr_en) begin
      block_size <= cfg_wr_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_FILL);
    unique case (state)
      ST_FILL: begin
        if (in_valid && closes) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_PREP;
      ST_PREP: begin
        state_next = sum_zero ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == LAST_BIT) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = idx_last ? ST_FILL : ST_LOAD;
      end
      default: state_next = ST_FILL;
    endcase
  end

  // block buffer: written on accept, read registered while draining
  always_ff @(posedge clk) begin
    if (in_accept) begin
      block_buffer[fill_count[IDX_W-1:0]] <= prob_value;
    end
    if (state == ST_LOAD) begin
      rd_data <= block_buffer[rd_idx];
    end
  end

  // fill count, running sum, read index
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      block_sum  <= '0;
      rd_idx     <= '0;
      blk_len    <= '0;
    end else begin
      if (in_accept) begin
        block_sum <= block_sum + {{(SUM_W - DATA_W){1'b0}}, prob_value};
        if (closes) begin
          fill_count <= '0;
          blk_len    <= fill_inc;
          rd_idx     <= '0;
        end else begin
          fill_count <= fill_inc;
        end
      end
      if (state == ST_EMIT && out_free) begin
        if (idx_last) begin
          block_sum <= '0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      bit_cnt <= '0;
      if (sum_zero) begin
        quot <= rd_data;
        rem  <= '0;
      end else if (!val_diff[SUM_W]) begin
        // value equals the sum: top quotient bit set
        quot <= QUOT_W'(1);
        rem  <= val_diff[SUM_W-1:0];
      end else begin
        quot <= '0;
        rem  <= {{(SUM_W - DATA_W){1'b0}}, rd_data};
      end
    end else if (state == ST_DIV) begin
      bit_cnt <= bit_cnt + BITS_W'(1);
      if (!rem_diff[SUM_W]) begin
        rem  <= rem_diff[SUM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[SUM_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      cond_value <= quot;
      block_last <= idx_last;
      zero_sum   <= sum_zero;
    end
  end

  // checks; a size change can leave the open block above the new size
  `BPN_ASSERT_SAME(a_rem_below_sum, clk, rst, state == ST_DIV, rem < block_sum)
  `BPN_ASSERT_SAME(a_quot_bound, clk, rst, out_valid && !zero_sum, cond_value <= 32'h8000_0000)
  `BPN_ASSERT_SAME(a_fill_bound, clk, rst, state == ST_FILL, fill_count < MAX_BLOCK_CNT)
  `BPN_ASSERT_NEXT(a_accept_moves, clk, rst, in_accept, fill_count != '0 || state == ST_LOAD)

endmodule
